>>> rtl/vadsr_pkg.sv
`timescale 1ns / 1ps

package vadsr_pkg;

  // default voice count
  localparam int unsigned VOICES_DEF = 64;

  // full envelope level
  localparam logic [7:0] FULL_LEVEL = 8'd128;

  // serial divider widths
  localparam int unsigned DIV_W = 16;
  localparam int unsigned DEN_W = 8;

  // register indexes on the configuration port
  localparam logic [2:0] REG_ATTACK   = 3'd0;
  localparam logic [2:0] REG_DECAY    = 3'd1;
  localparam logic [2:0] REG_SUST_TCK = 3'd2;
  localparam logic [2:0] REG_SUST_LVL = 3'd3;
  localparam logic [2:0] REG_RELEASE  = 3'd4;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_TICK     = 2'd2,
    OP_WRAP     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_REL_REQ = 3'd4,
    PH_RELEASE = 3'd5,
    PH_WAIT    = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    DK_ATTACK  = 2'd0,
    DK_DECAY   = 2'd1,
    DK_RELEASE = 2'd2
  } div_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_DIV  = 2'd2,
    ST_DONE = 2'd3
  } state_e;

  typedef struct packed {
    logic [7:0] attack;
    logic [7:0] decay;
    logic [7:0] sust_ticks;
    logic [7:0] sust_level;
    logic [7:0] release_t;
  } cfg_t;

  // per-voice state entry
  typedef struct packed {
    phase_e     phase;
    logic [7:0] ticks;
    logic [7:0] level;
    logic [7:0] rel_start;
  } entry_t;

  // outcome of the phase rules, before the division
  typedef struct packed {
    entry_t           next;
    logic             need_div;
    div_kind_e        kind;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [7:0]       span;
  } rules_t;

endpackage

>>> rtl/vadsr_cfg.sv
`timescale 1ns / 1ps

module vadsr_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output vadsr_pkg::cfg_t    cfg_o
);
  import vadsr_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;
  logic [7:0] rd_val;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_ATTACK:   cfg_d.attack     = pwdata[7:0];
        REG_DECAY:    cfg_d.decay      = pwdata[7:0];
        REG_SUST_TCK: cfg_d.sust_ticks = pwdata[7:0];
        REG_SUST_LVL: cfg_d.sust_level = pwdata[7:0];
        REG_RELEASE:  cfg_d.release_t  = pwdata[7:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{attack:     8'd0,
                 decay:      8'd0,
                 sust_ticks: 8'd0,
                 sust_level: FULL_LEVEL,
                 release_t:  8'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_ATTACK:   rd_val = cfg_q.attack;
      REG_DECAY:    rd_val = cfg_q.decay;
      REG_SUST_TCK: rd_val = cfg_q.sust_ticks;
      REG_SUST_LVL: rd_val = cfg_q.sust_level;
      REG_RELEASE:  rd_val = cfg_q.release_t;
      default:      rd_val = 8'd0;
    endcase
  end

  assign prdata = {24'd0, rd_val};
  assign cfg_o  = cfg_q;

endmodule

>>> rtl/vadsr_rules.sv
`timescale 1ns / 1ps

module vadsr_rules (
  input  vadsr_pkg::op_e    op_i,
  input  vadsr_pkg::entry_t cur_i,
  input  vadsr_pkg::cfg_t   cfg_i,
  output vadsr_pkg::rules_t rules_o
);
  import vadsr_pkg::*;

  phase_e     ph;
  logic [7:0] t;
  logic [7:0] lv;
  logic [7:0] rs;
  logic [7:0] s;
  logic [7:0] span;
  logic [7:0] mul_a;
  logic [7:0] mul_b;
  logic [7:0] den;
  logic       need;
  div_kind_e  kind;
  logic [15:0] prod;

  // cascaded phase rules; at most one division is left over
  always_comb begin
    ph    = cur_i.phase;
    t     = cur_i.ticks;
    lv    = cur_i.level;
    rs    = cur_i.rel_start;
    s     = (cfg_i.sust_level > FULL_LEVEL) ? FULL_LEVEL : cfg_i.sust_level;
    span  = FULL_LEVEL - s;
    mul_a = 8'd0;
    mul_b = 8'd0;
    den   = 8'd1;
    need  = 1'b0;
    kind  = DK_ATTACK;
    case (op_i)
      OP_NOTE_ON: begin
        ph = PH_ATTACK;
        t  = 8'd0;
      end
      OP_NOTE_OFF: begin
        if (ph == PH_ATTACK || ph == PH_DECAY || ph == PH_SUSTAIN) begin
          ph = PH_REL_REQ;
        end
      end
      OP_TICK: begin
        if (ph == PH_IDLE) begin
          t  = 8'd0;
          lv = 8'd0;
        end
        if (ph == PH_ATTACK) begin
          if (t < cfg_i.attack) begin
            t    = t + 8'd1;
            need = 1'b1;
            kind = DK_ATTACK;
            den  = cfg_i.attack;
          end else begin
            lv = FULL_LEVEL;
            t  = 8'd0;
            ph = PH_DECAY;
          end
        end
        if (ph == PH_DECAY) begin
          if (t < cfg_i.decay) begin
            t     = t + 8'd1;
            need  = 1'b1;
            kind  = DK_DECAY;
            mul_a = span;
            mul_b = t;
            den   = (cfg_i.decay > 8'd1) ? (cfg_i.decay - 8'd1) : 8'd1;
          end else begin
            t  = 8'd0;
            ph = PH_SUSTAIN;
          end
        end
        if (ph == PH_SUSTAIN) begin
          lv = s;
          rs = s;
          if (cfg_i.sust_ticks != 8'd0) begin
            if (t < cfg_i.sust_ticks) begin
              t = t + 8'd1;
            end else begin
              t  = 8'd0;
              ph = PH_RELEASE;
            end
          end
        end
        if (ph == PH_REL_REQ) begin
          t  = 8'd0;
          rs = lv;
          ph = PH_RELEASE;
        end
        if (ph == PH_RELEASE) begin
          if (t < cfg_i.release_t) begin
            t     = t + 8'd1;
            need  = 1'b1;
            kind  = DK_RELEASE;
            mul_a = rs;
            mul_b = cfg_i.release_t - t;
            den   = cfg_i.release_t;
          end else begin
            t  = 8'd0;
            ph = PH_WAIT;
          end
        end
      end
      OP_WRAP: begin
        if (ph == PH_WAIT) begin
          ph = PH_IDLE;
        end
      end
      default: ph = cur_i.phase;
    endcase
  end

  // single 8x8 product feeds the divider dividend
  assign prod = mul_a * mul_b;

  always_comb begin
    rules_o.next.phase     = ph;
    rules_o.next.ticks     = t;
    rules_o.next.level     = lv;
    rules_o.next.rel_start = rs;
    rules_o.need_div       = need;
    rules_o.kind           = kind;
    rules_o.num            = (kind == DK_ATTACK) ? {1'b0, t, 7'd0} : prod;
    rules_o.den            = den;
    rules_o.span           = span;
  end

endmodule

>>> rtl/vadsr_div.sv
`timescale 1ns / 1ps

module vadsr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [vadsr_pkg::DIV_W-1:0]   dividend_i,
  input  logic [vadsr_pkg::DEN_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [vadsr_pkg::DIV_W-1:0]   quotient_o
);
  import vadsr_pkg::*;

  localparam int unsigned CntW = $clog2(DIV_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             ge;

  // one restoring step: shift in the next dividend bit, trial subtract
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b0, den_q};
  assign ge      = ~diff[DEN_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/voice_adsr_envelope.sv
`timescale 1ns / 1ps

// Polyphonic ADSR envelope engine. Each input transaction names a voice and an
// operation (note on, note off, tick, oscillator wrap) and yields one output
// transaction with the voice's level (0..128) and phase after the step. Items
// are processed one at a time: no new item is accepted until the last one has
// been loaded into the output register. Each item passes through the READ and
// DONE states; a tick that computes an attack, decay or release level also
// waits in the DIV state on the 16-bit restoring divider, which retires one
// quotient bit per cycle. A full output register that is not being taken
// holds the engine until it drains. Voice state lives in a VOICES-entry
// memory with one valid flag per voice, so it reads as zero right after reset
// with no clearing pass. A voice index at or above VOICES returns level 0,
// phase 0 and changes nothing. Configuration registers sit at byte addresses
// 0, 4, 8, 12 and 16; the user is to write them only while the engine is
// idle, and the block itself does not enforce this.

module voice_adsr_envelope #(
  parameter int unsigned VOICES = vadsr_pkg::VOICES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [1:0] op, [7:2] voice
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [7:0] level, [10:8] phase, [15:11] zero
);
  import vadsr_pkg::*;

  localparam int unsigned IdxW = (VOICES > 1) ? $clog2(VOICES) : 1;

  state_e           state_q, state_d;
  cfg_t             cfg;
  logic             in_accept;
  logic [5:0]       in_voice;
  logic [IdxW-1:0]  in_idx;
  op_e              op_q;
  logic [IdxW-1:0]  idx_q;
  logic             in_range_q;
  entry_t           mem [VOICES];
  logic [VOICES-1:0] vld_q;
  entry_t           rd_q;
  logic             rd_vld_q;
  entry_t           cur;
  rules_t           rules;
  rules_t           rule_q;
  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] quo;
  entry_t           fin;
  logic [7:0]       drop;
  logic             load_out;
  logic             out_free;
  logic             m_valid_q, m_valid_d;
  logic [7:0]       out_level_q;
  logic [2:0]       out_phase_q;

  vadsr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_accept = s_axis_tvalid_i & s_axis_tready_o;
  assign in_voice  = s_axis_tdata_i[7:2];
  assign in_idx    = IdxW'(in_voice);

  // capture the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= OP_NOTE_ON;
      idx_q      <= '0;
      in_range_q <= 1'b0;
    end else if (in_accept) begin
      op_q       <= op_e'(s_axis_tdata_i[1:0]);
      idx_q      <= in_idx;
      in_range_q <= (32'(in_voice) < VOICES);
    end
  end

  // voice state memory, registered read
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_q <= mem[in_idx];
    end
    if (load_out && in_range_q) begin
      mem[idx_q] <= fin;
    end
  end

  // per-voice valid flags stand in for the reset of the memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (in_accept) begin
        rd_vld_q <= vld_q[in_idx];
      end
      if (load_out && in_range_q) begin
        vld_q[idx_q] <= 1'b1;
      end
    end
  end

  assign cur = rd_vld_q ? rd_q : '0;

  vadsr_rules u_rules (
    .op_i    (op_q),
    .cur_i   (cur),
    .cfg_i   (cfg),
    .rules_o (rules)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rule_q <= rules;
    end
  end

  vadsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rules.num),
    .divisor_i  (rules.den),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // final level from the quotient
  always_comb begin
    fin  = rule_q.next;
    drop = 8'd0;
    if (rule_q.need_div) begin
      case (rule_q.kind)
        DK_ATTACK:  fin.level = quo[7:0];
        DK_DECAY: begin
          drop      = (quo > {8'd0, rule_q.span}) ? rule_q.span : quo[7:0];
          fin.level = FULL_LEVEL - drop;
        end
        DK_RELEASE: fin.level = quo[7:0];
        default:    fin.level = rule_q.next.level;
      endcase
    end
  end

  assign out_free = ~m_valid_q | m_axis_tready_i;

  // sequencer
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    load_out        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (in_range_q && rules.need_div) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  assign m_valid_d = (m_valid_q & ~m_axis_tready_i) | load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_level_q <= in_range_q ? fin.level : 8'd0;
      out_phase_q <= in_range_q ? fin.phase : 3'd0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_phase_q, out_level_q};

endmodule
